// ===== rtl/tcwf_pkg.sv =====
// Shared types and constants for the tryptic cleavage window finder.
package tcwf_pkg;
	localparam int unsigned BoundaryDepth = 4096;
	localparam int unsigned AddrW = $clog2(BoundaryDepth);
	localparam int unsigned CountW = AddrW + 1;
	localparam int unsigned PosW = 32;
	localparam int unsigned SegW = 13;
	localparam int unsigned EntryW = PosW + SegW;
	localparam int unsigned MaxResults = 64;
	localparam int unsigned NumW = $clog2(MaxResults) + 1;
	localparam logic [7:0] SymBarrier = 8'h23;
	localparam logic [7:0] SymK = 8'h4B;
	localparam logic [7:0] SymR = 8'h52;
	localparam logic [7:0] SymP = 8'h50;
	localparam logic [1:0] FuncLoad = 2'd0;
	localparam logic [1:0] FuncQuery = 2'd1;
	localparam logic [1:0] FuncClear = 2'd2;
	localparam logic [1:0] FuncUnused = 2'd3;
	localparam logic [0:0] RegMaxMissed = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SRCH, ST_SCMP, ST_ACMP, ST_SICMP, ST_ECMP,
		ST_OUTER, ST_OCMP, ST_INNER, ST_ICMP, ST_FIN
	} state_t;
endpackage

// ===== rtl/tcwf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module tcwf_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/tryptic_cleavage_window_finder_core.sv =====
// Top level: boundary table, binary search sequencer and window enumeration.
// A load, clear or unused function is handled in the idle state. A query runs two
// binary searches over the boundary table through its single registered read port,
// each probe reading in ST_SRCH and comparing in ST_SCMP, then a few single reads,
// and then walks the start boundaries and the candidate windows, up to (max_missed+1)^2
// candidates; results leave through an output register, a held-off output stalls
// the enumeration, and s_tready is low while a query runs.
module tryptic_cleavage_window_finder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // symbol[7:0], query_pos[39:8], query_len[55:40]
	input  logic [1:0]  s_tuser,  // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // window_start[31:0], window_end[63:32]
	output logic        m_tlast,
	output logic [1:0]  m_tuser,  // found[0], table_overflow[1]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int unsigned AW = tcwf_pkg::AddrW;
	localparam int unsigned CW = tcwf_pkg::CountW;
	localparam int unsigned PW = tcwf_pkg::PosW;
	localparam int unsigned SW = tcwf_pkg::SegW;
	localparam int unsigned NW = tcwf_pkg::NumW;

	tcwf_pkg::state_t state_q, state_d;

	logic [2:0]    max_missed_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] text_pos_q;
	logic [SW-1:0] seg_cnt_q;
	logic [7:0]    prev_sym_q;
	logic          inside_q;
	logic          ovf_q;

	logic [CW-1:0] lo_q, hi_q, mid_q;
	logic [PW:0]   key_q;
	logic          phase_q;
	logic [PW-1:0] qpos_q;
	logic [15:0]   qlen_q;
	logic [AW-1:0] si_q;
	logic [CW-1:0] ei_q;
	logic [SW-1:0] seg_q;
	logic [3:0]    ds_q, de_q;
	logic [PW-1:0] spos_q;
	logic [CW-1:0] s_q;
	logic [NW-1:0] n_q;
	logic          pend_v_q;
	logic [PW-1:0] pend_s_q, pend_e_q;

	logic          m_valid_q, m_last_q, m_found_q, m_ovf_q;
	logic [PW-1:0] m_start_q, m_end_q;

	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr, ram_raddr;
	logic [AW-1:0]                 ram_raddr_q;
	logic [tcwf_pkg::EntryW-1:0]   ram_rdata;
	logic [PW-1:0]                 rd_pos;
	logic [SW-1:0]                 rd_seg;

	logic [7:0]    in_sym;
	logic [PW-1:0] in_pos;
	logic [15:0]   in_len;
	logic          accept, add_bnd;
	logic [CW:0]   mid_sum;
	logic [CW-1:0] mid_c;
	logic [CW:0]   e_c;
	logic [CW:0]   s_c;
	logic          out_free;
	logic          qual;

	assign in_sym = s_tdata[7:0];
	assign in_pos = s_tdata[39:8];
	assign in_len = s_tdata[55:40];
	assign s_tready = (state_q == tcwf_pkg::ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign rd_pos = ram_rdata[PW-1:0];
	assign rd_seg = ram_rdata[tcwf_pkg::EntryW-1:PW];
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_c = mid_sum[CW:1];
	assign e_c = {1'b0, ei_q} + {{(CW-3){1'b0}}, de_q};
	assign s_c = {2'b0, si_q} - {{(CW-3){1'b0}}, ds_q};

	always_comb begin
		add_bnd = 1'b0;
		if (in_sym == tcwf_pkg::SymBarrier) begin
			add_bnd = inside_q;
		end else if (!inside_q) begin
			add_bnd = 1'b1;
		end else if ((prev_sym_q == tcwf_pkg::SymK || prev_sym_q == tcwf_pkg::SymR) &&
			in_sym != tcwf_pkg::SymP) begin
			add_bnd = 1'b1;
		end
	end

	assign ram_we = accept && s_tuser == tcwf_pkg::FuncLoad && add_bnd &&
		count_q != CW'(tcwf_pkg::BoundaryDepth);
	assign ram_waddr = count_q[AW-1:0];

	tcwf_ram #(.Width(tcwf_pkg::EntryW), .Depth(tcwf_pkg::BoundaryDepth)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({seg_cnt_q, text_pos_q}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// candidate window check on the entry read at e
	assign qual = (e_c[CW-1:0] > s_q) &&
		((e_c[CW-1:0] - s_q - CW'(1)) <= CW'(max_missed_q)) &&
		(rd_pos > spos_q) && (n_q < NW'(tcwf_pkg::MaxResults));

	always_comb begin
		state_d = state_q;
		ram_raddr = mid_c[AW-1:0];
		case (state_q)
			tcwf_pkg::ST_IDLE: begin
				if (accept && s_tuser == tcwf_pkg::FuncQuery) begin
					state_d = (count_q == '0) ? tcwf_pkg::ST_FIN : tcwf_pkg::ST_SRCH;
				end
			end
			tcwf_pkg::ST_SRCH: begin
				if (lo_q < hi_q) begin
					state_d = tcwf_pkg::ST_SCMP;
				end else if (!phase_q) begin
					if (lo_q < count_q) begin
						ram_raddr = lo_q[AW-1:0];
						state_d = tcwf_pkg::ST_ACMP;
					end else begin
						ram_raddr = AW'(count_q - CW'(1));
						state_d = tcwf_pkg::ST_SICMP;
					end
				end else if (lo_q < count_q) begin
					ram_raddr = lo_q[AW-1:0];
					state_d = tcwf_pkg::ST_ECMP;
				end else begin
					state_d = tcwf_pkg::ST_FIN;
				end
			end
			tcwf_pkg::ST_SCMP: state_d = tcwf_pkg::ST_SRCH;
			tcwf_pkg::ST_ACMP: begin
				if (rd_pos == qpos_q) begin
					ram_raddr = lo_q[AW-1:0];
					state_d = tcwf_pkg::ST_SICMP;
				end else if (lo_q == '0) begin
					state_d = tcwf_pkg::ST_FIN;
				end else begin
					ram_raddr = AW'(lo_q - CW'(1));
					state_d = tcwf_pkg::ST_SICMP;
				end
			end
			tcwf_pkg::ST_SICMP: begin
				state_d = (rd_pos > qpos_q) ? tcwf_pkg::ST_FIN : tcwf_pkg::ST_SRCH;
			end
			tcwf_pkg::ST_ECMP: begin
				state_d = (rd_seg == seg_q) ? tcwf_pkg::ST_OUTER : tcwf_pkg::ST_FIN;
			end
			tcwf_pkg::ST_OUTER: begin
				ram_raddr = s_c[AW-1:0];
				if (ds_q <= {1'b0, max_missed_q} && {{(CW-4){1'b0}}, ds_q} <= {1'b0, si_q} &&
					n_q < NW'(tcwf_pkg::MaxResults)) begin
					state_d = tcwf_pkg::ST_OCMP;
				end else begin
					state_d = tcwf_pkg::ST_FIN;
				end
			end
			tcwf_pkg::ST_OCMP: begin
				state_d = (rd_seg == seg_q) ? tcwf_pkg::ST_INNER : tcwf_pkg::ST_FIN;
			end
			tcwf_pkg::ST_INNER: begin
				ram_raddr = e_c[AW-1:0];
				if (de_q <= {1'b0, max_missed_q} && e_c < {1'b0, count_q}) begin
					state_d = tcwf_pkg::ST_ICMP;
				end else begin
					state_d = tcwf_pkg::ST_OUTER;
				end
			end
			tcwf_pkg::ST_ICMP: begin
				// keep the end entry on the read port while the output is held off
				ram_raddr = e_c[AW-1:0];
				if (rd_seg != seg_q) begin
					state_d = tcwf_pkg::ST_OUTER;
				end else if (!(qual && pend_v_q && !out_free)) begin
					state_d = tcwf_pkg::ST_INNER;
				end
			end
			tcwf_pkg::ST_FIN: begin
				if (out_free) begin
					state_d = tcwf_pkg::ST_IDLE;
				end
			end
			default: state_d = tcwf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcwf_pkg::ST_IDLE;
			max_missed_q <= 3'd2;
			count_q <= '0;
			text_pos_q <= '0;
			seg_cnt_q <= '0;
			prev_sym_q <= tcwf_pkg::SymBarrier;
			inside_q <= 1'b0;
			ovf_q <= 1'b0;
			pend_v_q <= 1'b0;
			m_valid_q <= 1'b0;
			n_q <= '0;
		end else begin
			state_q <= state_d;
			if (psel && penable && pwrite && paddr[2] == tcwf_pkg::RegMaxMissed) begin
				max_missed_q <= pwdata[2:0];
			end
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				tcwf_pkg::ST_IDLE: begin
					if (accept && s_tuser == tcwf_pkg::FuncLoad) begin
						if (add_bnd) begin
							if (count_q == CW'(tcwf_pkg::BoundaryDepth)) begin
								ovf_q <= 1'b1;
							end else begin
								count_q <= count_q + CW'(1);
							end
						end
						if (in_sym == tcwf_pkg::SymBarrier) begin
							if (inside_q) begin
								seg_cnt_q <= seg_cnt_q + SW'(1);
							end
							inside_q <= 1'b0;
						end else begin
							inside_q <= 1'b1;
						end
						prev_sym_q <= in_sym;
						text_pos_q <= text_pos_q + PW'(1);
					end else if (accept && s_tuser == tcwf_pkg::FuncClear) begin
						count_q <= '0;
						text_pos_q <= '0;
						seg_cnt_q <= '0;
						prev_sym_q <= tcwf_pkg::SymBarrier;
						inside_q <= 1'b0;
						ovf_q <= 1'b0;
					end else if (accept && s_tuser == tcwf_pkg::FuncQuery) begin
						n_q <= '0;
						pend_v_q <= 1'b0;
					end
				end
				tcwf_pkg::ST_ICMP: begin
					if (rd_seg == seg_q && qual && !(pend_v_q && !out_free)) begin
						if (pend_v_q) begin
							m_valid_q <= 1'b1;
						end
						pend_v_q <= 1'b1;
						n_q <= n_q + NW'(1);
					end
				end
				tcwf_pkg::ST_FIN: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						pend_v_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			tcwf_pkg::ST_IDLE: begin
				qpos_q <= in_pos;
				qlen_q <= in_len;
				lo_q <= '0;
				hi_q <= count_q;
				key_q <= {1'b0, in_pos};
				phase_q <= 1'b0;
			end
			tcwf_pkg::ST_SRCH: begin
				mid_q <= mid_c;
				if (!(lo_q < hi_q) && phase_q) begin
					ei_q <= lo_q;
				end
			end
			tcwf_pkg::ST_SCMP: begin
				if ({1'b0, rd_pos} < key_q) begin
					lo_q <= mid_q + CW'(1);
				end else begin
					hi_q <= mid_q;
				end
			end
			tcwf_pkg::ST_SICMP: begin
				seg_q <= rd_seg;
				si_q <= ram_raddr_q;
				lo_q <= '0;
				hi_q <= count_q;
				key_q <= {1'b0, qpos_q} + {{(PW-15){1'b0}}, qlen_q};
				phase_q <= 1'b1;
				ds_q <= '0;
			end
			tcwf_pkg::ST_OUTER: begin
				s_q <= s_c[CW-1:0];
			end
			tcwf_pkg::ST_OCMP: begin
				spos_q <= rd_pos;
				de_q <= '0;
				if (rd_seg == seg_q) begin
					ds_q <= ds_q;
				end
			end
			tcwf_pkg::ST_INNER: begin
				if (!(de_q <= {1'b0, max_missed_q} && e_c < {1'b0, count_q})) begin
					ds_q <= ds_q + 4'd1;
				end
			end
			tcwf_pkg::ST_ICMP: begin
				if (rd_seg != seg_q) begin
					ds_q <= ds_q + 4'd1;
				end else if (!(qual && pend_v_q && !out_free)) begin
					de_q <= de_q + 4'd1;
					if (qual) begin
						pend_s_q <= spos_q;
						pend_e_q <= rd_pos;
						if (pend_v_q) begin
							m_start_q <= pend_s_q;
							m_end_q <= pend_e_q;
							m_found_q <= 1'b1;
							m_last_q <= 1'b0;
							m_ovf_q <= ovf_q;
						end
					end
				end
			end
			tcwf_pkg::ST_FIN: begin
				if (out_free) begin
					m_start_q <= pend_v_q ? pend_s_q : '0;
					m_end_q <= pend_v_q ? pend_e_q : '0;
					m_found_q <= pend_v_q;
					m_last_q <= 1'b1;
					m_ovf_q <= ovf_q;
				end
			end
			default: ;
		endcase
	end

	// address of the last read, kept for the start index
	always_ff @(posedge clk) begin
		ram_raddr_q <= ram_raddr;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {m_end_q, m_start_q};
	assign m_tlast = m_last_q;
	assign m_tuser = {m_ovf_q, m_found_q};
	assign prdata = {29'b0, max_missed_q};
	assign pready = 1'b1;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(tcwf_pkg::BoundaryDepth))
		else $error("boundary count beyond table depth");
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> count_q == CW'(tcwf_pkg::BoundaryDepth))
		else $error("overflow flagged with room left");
	a_pend_counted: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> n_q != '0)
		else $error("pending window not counted");
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tcwf_pkg::ST_IDLE |-> !pend_v_q)
		else $error("window left pending after query");
endmodule
